FILE: sv/isaac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isaac_pkg
// Shared constants and helpers for the ISAAC64 generator.
// ----------------------------------------------------------------------------
package isaac_pkg;
    localparam int unsigned LOG_SIZE_DEFAULT = 8;
    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c13;

    // op codes of an input beat
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SEED = 1'b1;

    typedef logic [7:0][63:0] scram_t;

    // first four steps of the eight-word scramble
    function automatic scram_t scramble_lo(input scram_t s_in);
        scram_t s;
        s = s_in;
        s[0] = s[0] - s[4]; s[5] = s[5] ^ (s[7] >> 9);  s[7] = s[7] + s[0];
        s[1] = s[1] - s[5]; s[6] = s[6] ^ (s[0] << 9);  s[0] = s[0] + s[1];
        s[2] = s[2] - s[6]; s[7] = s[7] ^ (s[1] >> 23); s[1] = s[1] + s[2];
        s[3] = s[3] - s[7]; s[0] = s[0] ^ (s[2] << 15); s[2] = s[2] + s[3];
        return s;
    endfunction

    // last four steps of the eight-word scramble
    function automatic scram_t scramble_hi(input scram_t s_in);
        scram_t s;
        s = s_in;
        s[4] = s[4] - s[0]; s[1] = s[1] ^ (s[3] >> 14); s[3] = s[3] + s[4];
        s[5] = s[5] - s[1]; s[2] = s[2] ^ (s[4] << 20); s[4] = s[4] + s[5];
        s[6] = s[6] - s[2]; s[3] = s[3] ^ (s[5] >> 17); s[5] = s[5] + s[6];
        s[7] = s[7] - s[3]; s[4] = s[4] ^ (s[6] << 14); s[6] = s[6] + s[7];
        return s;
    endfunction

    // one full scramble of the eight-word mixing state
    function automatic scram_t scramble(input scram_t s_in);
        return scramble_hi(scramble_lo(s_in));
    endfunction
endpackage
`default_nettype wire

FILE: sv/isaac_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isaac_ram
// Single-port synchronous word memory with registered read.
// ----------------------------------------------------------------------------
module isaac_ram
    import isaac_pkg::*;
#(
    parameter int unsigned LOG_SIZE = LOG_SIZE_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [LOG_SIZE-1:0] addr,
    input  wire logic [63:0]         wdata,
    output      logic [63:0]         rdata
);
    logic [63:0] mem [0:(1<<LOG_SIZE)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: sv/isaac64_random_generator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isaac64_random_generator_top
// ISAAC64 generator with mix memory and result buffer in synchronous RAMs.
// ----------------------------------------------------------------------------
// A draw with words left in the buffer goes from idle through S_DRD to S_DOUT,
// which gives its strobe, and the next item is taken back in idle. A draw that
// finds the buffer exhausted first regenerates it, word by word through the
// single-port mix memory in states S_G0 to S_G5, then reads through S_DRD and
// S_DOUT. A reseed takes a start state (S_SLOAD), two mixing passes over groups
// of eight words (S_SRD and S_SMIX per word, then S_SCR, then S_SWR per word)
// and a block. The first item after reset is preceded by a pass that clears
// both memories. A result strobe lasts one cycle and cannot be held off; busy
// is high while an item is in progress.
module isaac64_random_generator_top
    import isaac_pkg::*;
#(
    parameter int unsigned LOG_SIZE = LOG_SIZE_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic        op,
    input  wire logic [63:0] seed_value,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic        cfg_data,
    output      logic        strobe,
    output      logic [63:0] random_value
);
    localparam int unsigned SIZE = 1 << LOG_SIZE;
    localparam int unsigned HALF = SIZE / 2;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_CLR   = 15'b000000000000010,
        S_DRD   = 15'b000000000000100,
        S_DOUT  = 15'b000000000001000,
        S_SLOAD = 15'b000000000010000,
        S_SWR   = 15'b000000000100000,
        S_SRD   = 15'b000000001000000,
        S_SMIX  = 15'b000000010000000,
        S_G0    = 15'b000000100000000,
        S_G1    = 15'b000001000000000,
        S_G2    = 15'b000010000000000,
        S_G3    = 15'b000100000000000,
        S_G4    = 15'b001000000000000,
        S_G5    = 15'b010000000000000,
        S_SCR   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic               mode_reg;
    logic [LOG_SIZE:0]  cnt_reg, cnt_next;
    logic [LOG_SIZE:0]  idx_reg, idx_next;     // sweep index
    logic [2:0]         sub_reg, sub_next;     // word inside a group of eight
    logic               pass_reg, pass_next;   // second mix pass
    logic               post_reg, post_next;   // 1: block is for a draw; in S_CLR, 1: reseed pending
    logic               seeded_reg, seeded_next;
    logic [63:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [63:0] x_reg, x_next, y_reg, y_next, seed_reg, seed_next;
    scram_t      s_reg, s_next;

    // mix memory port
    logic                m_we;
    logic [LOG_SIZE-1:0] m_addr;
    logic [63:0]         m_wdata, m_rdata;
    // result buffer port
    logic                r_we;
    logic [LOG_SIZE-1:0] r_addr;
    logic [63:0]         r_wdata, r_rdata;

    isaac_ram #(.LOG_SIZE(LOG_SIZE)) u_mix (
        .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
    );
    isaac_ram #(.LOG_SIZE(LOG_SIZE)) u_res (
        .clk(clk), .we(r_we), .addr(r_addr), .wdata(r_wdata), .rdata(r_rdata)
    );

    logic [LOG_SIZE-1:0] i_w;
    logic [63:0]         mx;
    logic [63:0]         seed_w;
    logic [63:0]         fold;
    scram_t              s_add;
    logic [LOG_SIZE-1:0] cnt_dec;

    assign i_w     = idx_reg[LOG_SIZE-1:0];
    assign cnt_dec = LOG_SIZE'(cnt_reg - 1'b1);
    assign seed_w  = mode_reg ? {seed_value[31:0], seed_value[31:0]} : seed_value;
    assign fold    = {32'd0, r_rdata[63:32] ^ r_rdata[31:0]};
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;

    always_comb
    begin
        case (i_w[1:0])
            2'd0:    mx = ~(a_reg ^ (a_reg << 21));
            2'd1:    mx = a_reg ^ (a_reg >> 5);
            2'd2:    mx = a_reg ^ (a_reg << 12);
            default: mx = a_reg ^ (a_reg >> 33);
        endcase
        s_add = s_reg;
        s_add[sub_reg] = s_reg[sub_reg] + (pass_reg ? m_rdata : seed_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        sub_next    = sub_reg;
        pass_next   = pass_reg;
        post_next   = post_reg;
        seeded_next = seeded_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg;
        x_next = x_reg; y_next = y_reg; seed_next = seed_reg;
        s_next = s_reg;
        m_we = 1'b0; m_addr = i_w; m_wdata = 64'd0;
        r_we = 1'b0; r_addr = i_w; r_wdata = 64'd0;
        strobe = 1'b0;
        random_value = 64'd0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!seeded_reg)
                    begin
                        // first item after reset: zero both memories first
                        idx_next   = '0;
                        state_next = S_CLR;
                        post_next  = (op == OP_SEED);
                        seed_next  = seed_w;
                    end
                    else if (op == OP_SEED)
                    begin
                        seed_next  = seed_w;
                        idx_next   = '0;
                        sub_next   = '0;
                        pass_next  = 1'b0;
                        a_next = '0; b_next = '0; c_next = '0;
                        state_next = S_SLOAD;
                    end
                    else if (cnt_reg == '0)
                    begin
                        post_next  = 1'b1;
                        c_next     = c_reg + 64'd1;
                        b_next     = b_reg + c_reg + 64'd1;
                        idx_next   = '0;
                        state_next = S_G0;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = S_DRD;
                    end
                end
            end
            S_CLR:
            begin
                m_we = 1'b1; r_we = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (LOG_SIZE+1)'(SIZE - 1))
                begin
                    seeded_next = 1'b1;
                    state_next  = S_IDLE;
                    if (post_reg)
                    begin
                        // pending reseed
                        idx_next = '0; sub_next = '0; pass_next = 1'b0;
                        a_next = '0; b_next = '0; c_next = '0;
                        state_next = S_SLOAD;
                    end
                    else
                    begin
                        post_next = 1'b1;
                        c_next = c_reg + 64'd1;
                        b_next = b_reg + c_reg + 64'd1;
                        idx_next = '0;
                        state_next = S_G0;
                    end
                end
            end
            S_DRD:
            begin
                r_addr = cnt_reg[LOG_SIZE-1:0];
                state_next = S_DOUT;
            end
            S_DOUT:
            begin
                strobe = 1'b1;
                random_value = mode_reg ? fold : r_rdata;
                state_next = S_IDLE;
            end
            S_SLOAD:
            begin
                // golden-ratio start, four scrambles
                s_next = scramble(scramble(scramble(scramble({8{GOLDEN}}))));
                state_next = S_SRD;
            end
            S_SRD:
            begin
                // fill result buffer with the seed while the first pass runs
                r_we = !pass_reg; r_wdata = seed_reg;
                state_next = S_SMIX;
            end
            S_SMIX:
            begin
                // accumulate one word per visit; scramble after the eighth
                s_next = s_add;
                sub_next = sub_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
                state_next = S_SRD;
                if (sub_reg == 3'd7)
                begin
                    s_next = scramble_lo(s_add);
                    idx_next = idx_reg - (LOG_SIZE+1)'(7);
                    sub_next = '0;
                    state_next = S_SCR;
                end
            end
            S_SCR:
            begin
                s_next = scramble_hi(s_reg);
                state_next = S_SWR;
            end
            S_SWR:
            begin
                m_we = 1'b1; m_wdata = s_reg[sub_reg];
                sub_next = sub_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
                if (sub_reg == 3'd7)
                begin
                    sub_next = '0;
                    state_next = S_SRD;
                    if (idx_reg == (LOG_SIZE+1)'(SIZE - 1))
                    begin
                        idx_next = '0;
                        if (pass_reg)
                        begin
                            post_next = 1'b0;
                            c_next = 64'd1;
                            b_next = 64'd1;
                            state_next = S_G0;
                        end
                        else
                        begin
                            pass_next = 1'b1;
                        end
                    end
                end
            end
            // block generation: read x, read m[i+half], read m[x], write y,
            // read m[y], write result
            S_G0:
            begin
                state_next = S_G1;
            end
            S_G1:
            begin
                x_next = m_rdata;
                m_addr = LOG_SIZE'(i_w + LOG_SIZE'(HALF));
                state_next = S_G2;
            end
            S_G2:
            begin
                a_next = mx + m_rdata;
                m_addr = x_reg[LOG_SIZE+2:3];
                state_next = S_G3;
            end
            S_G3:
            begin
                y_next = m_rdata + a_reg + b_reg;
                state_next = S_G4;
            end
            S_G4:
            begin
                m_we = 1'b1; m_wdata = y_reg;
                state_next = S_G5;
            end
            S_G5:
            begin
                m_addr = y_reg[2*LOG_SIZE+2:LOG_SIZE+3];
                state_next = S_G5;
                if (sub_reg == 3'd1)
                begin
                    b_next = m_rdata + x_reg;
                    r_we = 1'b1; r_wdata = m_rdata + x_reg;
                    sub_next = '0;
                    idx_next = idx_reg + 1'b1;
                    state_next = S_G0;
                    if (idx_reg == (LOG_SIZE+1)'(SIZE - 1))
                    begin
                        idx_next = '0;
                        if (post_reg)
                        begin
                            cnt_next = (LOG_SIZE+1)'(SIZE - 1);
                            state_next = S_DRD;
                        end
                        else
                        begin
                            cnt_next = (LOG_SIZE+1)'(SIZE);
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    sub_next = 3'd1;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_SRD)
        begin
            m_addr = i_w;
        end
        if (state_reg == S_DRD || state_reg == S_IDLE)
        begin
            r_addr = (state_reg == S_DRD) ? cnt_reg[LOG_SIZE-1:0] : cnt_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            sub_reg    <= '0;
            pass_reg   <= 1'b0;
            post_reg   <= 1'b0;
            seeded_reg <= 1'b0;
            a_reg <= '0; b_reg <= '0; c_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            sub_reg    <= sub_next;
            pass_reg   <= pass_next;
            post_reg   <= post_next;
            seeded_reg <= seeded_next;
            a_reg <= a_next; b_reg <= b_next; c_reg <= c_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        seed_reg <= seed_next;
        s_reg    <= s_next;
    end
endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the ISAAC64 generator against a cycle-free software predictor.
// Draws and reseeds are sent through the start/busy port. Each strobe is
// compared with the oldest predicted word. Both word modes are used, with
// varying sender idle profiles.
// ----------------------------------------------------------------------------
module tb
    import isaac_pkg::*;
();

    localparam int unsigned TBL  = 256;
    localparam int unsigned QUIET_LIMIT = 60000;
    localparam int unsigned DRAIN_CYCLES = 10000;

    class isaac_scoreboard;
        bit [63:0] mem [TBL];
        bit [63:0] rsl [TBL];
        bit [63:0] acc_a;
        bit [63:0] prev_b;
        bit [63:0] rounds;
        int unsigned remaining;
        bit        fold32;
        bit [63:0] s [8];
        bit [63:0] words_q [$];
        int unsigned errors;
        int unsigned draws;
        int unsigned seeds;

        function void set_mode(bit m);
            fold32 = m;
        endfunction

        function int unsigned pending();
            return words_q.size();
        endfunction

        function void refill();
            bit [63:0] a;
            bit [63:0] b;
            bit [63:0] mx;
            bit [63:0] x;
            bit [63:0] y;
            a = acc_a;
            rounds = rounds + 1;
            b = prev_b + rounds;
            for (int i = 0; i < TBL; i++)
            begin
                case (i % 4)
                    0: mx = ~(a ^ (a << 21));
                    1: mx = a ^ (a >> 5);
                    2: mx = a ^ (a << 12);
                    default: mx = a ^ (a >> 33);
                endcase
                x = mem[i];
                a = mx + mem[(i + TBL / 2) % TBL];
                y = mem[x[10:3]] + a + b;
                mem[i] = y;
                b = mem[y[18:11]] + x;
                rsl[i] = b;
            end
            prev_b = b;
            acc_a = a;
        endfunction

        function void mix8();
            s[0] -= s[4]; s[5] ^= s[7] >> 9;  s[7] += s[0];
            s[1] -= s[5]; s[6] ^= s[0] << 9;  s[0] += s[1];
            s[2] -= s[6]; s[7] ^= s[1] >> 23; s[1] += s[2];
            s[3] -= s[7]; s[0] ^= s[2] << 15; s[2] += s[3];
            s[4] -= s[0]; s[1] ^= s[3] >> 14; s[3] += s[4];
            s[5] -= s[1]; s[2] ^= s[4] << 20; s[4] += s[5];
            s[6] -= s[2]; s[3] ^= s[5] >> 17; s[5] += s[6];
            s[7] -= s[3]; s[4] ^= s[6] << 14; s[6] += s[7];
        endfunction

        function void reseed(bit [63:0] w);
            for (int i = 0; i < TBL; i++)
                rsl[i] = w;
            acc_a = 0;
            prev_b = 0;
            rounds = 0;
            for (int j = 0; j < 8; j++)
                s[j] = GOLDEN;
            for (int i = 0; i < 4; i++)
                mix8();
            for (int i = 0; i < TBL; i += 8)
            begin
                for (int j = 0; j < 8; j++)
                    s[j] += rsl[i + j];
                mix8();
                for (int j = 0; j < 8; j++)
                    mem[i + j] = s[j];
            end
            for (int i = 0; i < TBL; i += 8)
            begin
                for (int j = 0; j < 8; j++)
                    s[j] += mem[i + j];
                mix8();
                for (int j = 0; j < 8; j++)
                    mem[i + j] = s[j];
            end
            refill();
            remaining = TBL;
        endfunction

        function void note_item(bit op_i, bit [63:0] seed_i);
            bit [63:0] v;
            if (op_i == OP_SEED)
            begin
                seeds++;
                if (fold32)
                    reseed({seed_i[31:0], seed_i[31:0]});
                else
                    reseed(seed_i);
                return;
            end
            draws++;
            if (remaining == 0)
            begin
                refill();
                remaining = TBL - 1;
            end
            else
                remaining--;
            v = rsl[remaining % TBL];
            if (fold32)
                v = {32'h0, v[63:32] ^ v[31:0]};
            words_q.push_back(v);
        endfunction

        function void check(logic [63:0] got);
            bit [63:0] want;
            if (words_q.size() == 0)
            begin
                $display("%0t: unexpected strobe, random_value %h", $time, got);
                errors++;
                return;
            end
            want = words_q.pop_front();
            if (got !== want)
            begin
                $display("%0t: random_value expected %h actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        op;
    logic [63:0] seed_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        strobe;
    logic [63:0] random_value;

    isaac_scoreboard sb;
    int unsigned idle_pct;
    int unsigned quiet;
    int unsigned mode_writes;

    isaac64_random_generator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .seed_value   (seed_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .random_value (random_value)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check(random_value);
    end

    // cycles with no beat on any port
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(bit op_i, bit [63:0] seed_i);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        start      <= 1'b1;
        op         <= op_i;
        seed_value <= seed_i;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_item(op_i, seed_i);
    endtask

    // let queued words and any reseed walk finish before touching the register
    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(bit m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_mode(m);
        mode_writes++;
    endtask

    function automatic bit [63:0] pick_seed();
        case ($urandom_range(9))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        sb = new();
        quiet = 0;
        idle_pct = 0;
        mode_writes = 0;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_DRAW;
        seed_value = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b0);

        // unseeded draws start from an exhausted, all-zero state
        repeat (3) send_item(OP_DRAW, '1);
        send_item(OP_SEED, 64'h0);
        repeat (2) send_item(OP_DRAW, 64'h0);
        send_item(OP_SEED, '1);
        repeat (2) send_item(OP_DRAW, '0);
        send_item(OP_SEED, 64'h0123_4567_89ab_cdef);
        send_item(OP_DRAW, '0);
        settle();
        write_mode(1'b1);
        send_item(OP_SEED, 64'hffff_ffff_0000_0000);
        repeat (2) send_item(OP_DRAW, '0);
        send_item(OP_SEED, 64'h0000_0000_ffff_ffff);
        send_item(OP_DRAW, '1);
        settle();
        // mode switch after the seed: fold follows the current mode
        write_mode(1'b0);
        repeat (2) send_item(OP_DRAW, '0);
        settle();
        write_mode(1'b1);
        send_item(OP_DRAW, '0);

        for (int ph = 0; ph < 3; ph++)
        begin
            settle();
            write_mode(ph[0] ? 1'b1 : 1'b0);
            idle_pct = (ph == 0) ? 22 : ((ph == 1) ? 60 : 0);
            for (int n = 0; n < 200; n++)
            begin
                if ($urandom_range(99) < 1)
                    send_item(OP_SEED, pick_seed());
                else
                    send_item(OP_DRAW, {$urandom, $urandom});
            end
        end

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("run covered %0d draws and %0d reseeds over %0d mode writes",
                 sb.draws, sb.seeds, mode_writes);
        $display("both word modes, sender idle at 22, 60 and 0 percent");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
